[hdl/csvtl_pkg.sv]
`default_nettype none
package csvtl_pkg;

    localparam int VAL_W = 32;
    localparam int NDIG  = 10;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic CFG_PREFIX_CHARS  = 1'b0;
    localparam logic CFG_PREFIX_LENGTH = 1'b1;

    typedef struct packed {
        logic [4*NDIG-1:0] bcd;
        logic [3:0]        ndig;
        logic              neg;
        logic              last;
        logic              first;
    } csvtl_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } csvtl_q_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } csvtl_front_st_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREFIX,
        B_COLON,
        B_COMMA,
        B_SIGN,
        B_DIGIT,
        B_NL
    } csvtl_back_st_t;

endpackage
`default_nettype wire

[hdl/csvtl_front.sv]
`default_nettype none
module csvtl_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [31:0]         channel_value,
    input  wire logic                       frame_end,
    input  wire csvtl_pkg::csvtl_q_stat_t   q_stat,
    output logic                            push,
    output csvtl_pkg::csvtl_item_t          push_item
);
    import csvtl_pkg::*;

    csvtl_front_st_t   state_reg, state_next;
    logic [VAL_W-1:0]  mag_reg, mag_next;
    logic [4*NDIG-1:0] bcd_reg, bcd_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              last_reg, last_next;
    logic              first_reg, first_next;
    logic              frame_open_reg, frame_open_next;
    logic [4*NDIG-1:0] adj;
    logic [3:0]        ndig;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            frame_open_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_open_reg <= frame_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        last_reg  <= last_next;
        first_reg <= first_next;
    end

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        ndig = 4'd1;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                ndig = 4'(i + 1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        bcd_next        = bcd_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        last_next       = last_reg;
        first_next      = first_reg;
        frame_open_next = frame_open_reg;
        in_ready        = 1'b0;
        push            = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    neg_next        = channel_value[VAL_W-1];
                    mag_next        = channel_value[VAL_W-1] ?
                                      (32'd0 - $unsigned(channel_value)) :
                                      $unsigned(channel_value);
                    bcd_next        = '0;
                    cnt_next        = 5'd0;
                    last_next       = frame_end;
                    first_next      = !frame_open_reg;
                    frame_open_next = !frame_end;
                    state_next      = F_CONV;
                end
            end
            F_CONV:
            begin
                bcd_next = {adj[4*NDIG-2:0], mag_reg[VAL_W-1]};
                mag_next = {mag_reg[VAL_W-2:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_item.bcd   = bcd_reg;
    assign push_item.ndig  = ndig;
    assign push_item.neg   = neg_reg;
    assign push_item.last  = last_reg;
    assign push_item.first = first_reg;

endmodule
`default_nettype wire

[hdl/csvtl_queue.sv]
`default_nettype none
module csvtl_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire csvtl_pkg::csvtl_item_t push_item,
    input  wire logic                  pop,
    output csvtl_pkg::csvtl_item_t     pop_item,
    output csvtl_pkg::csvtl_q_stat_t   q_stat
);
    import csvtl_pkg::*;

    csvtl_item_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign pop_item     = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

endmodule
`default_nettype wire

[hdl/csvtl_back.sv]
`default_nettype none
module csvtl_back #(
    parameter int PREFIX_MAX = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire csvtl_pkg::csvtl_q_stat_t q_stat,
    input  wire csvtl_pkg::csvtl_item_t   pop_item,
    output logic                       pop,
    input  wire logic [63:0]           prefix_chars,
    input  wire logic [3:0]            prefix_length,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_byte,
    output logic                       run_last
);
    import csvtl_pkg::*;

    localparam int         PIDX_W = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
    localparam logic [3:0] PMAX4  = 4'(PREFIX_MAX);

    csvtl_back_st_t     st_reg, st_next;
    csvtl_item_t        item_reg, item_next;
    logic [3:0]         plen_reg, plen_next;
    logic [PIDX_W-1:0]  pidx_reg, pidx_next;
    logic [3:0]         didx_reg, didx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               run_last_reg, run_last_next;
    logic               advance;
    logic [3:0]         plen_sat;
    logic [3:0]         digit;
    csvtl_back_st_t     after_sep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        plen_reg     <= plen_next;
        pidx_reg     <= pidx_next;
        didx_reg     <= didx_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    assign advance   = !out_valid_reg || out_ready;
    assign plen_sat  = (prefix_length > PMAX4) ? PMAX4 : prefix_length;
    assign digit     = item_reg.bcd[{didx_reg, 2'b00} +: 4];
    assign after_sep = item_reg.neg ? B_SIGN : B_DIGIT;

    always_comb
    begin
        st_next        = st_reg;
        item_next      = item_reg;
        plen_next      = plen_reg;
        pidx_next      = pidx_reg;
        didx_next      = didx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        pop            = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop       = 1'b1;
                    item_next = pop_item;
                    plen_next = plen_sat;
                    pidx_next = '0;
                    didx_next = pop_item.ndig - 4'd1;
                    if (!pop_item.first)
                        st_next = B_COMMA;
                    else if (plen_sat != 4'd0)
                        st_next = B_PREFIX;
                    else if (pop_item.neg)
                        st_next = B_SIGN;
                    else
                        st_next = B_DIGIT;
                end
            end
            B_PREFIX:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = prefix_chars[{pidx_reg, 3'b000} +: 8];
                    run_last_next  = 1'b0;
                    if (4'(pidx_reg) + 4'd1 == plen_reg)
                        st_next = B_COLON;
                    else
                        pidx_next = pidx_reg + 1'b1;
                end
            end
            B_COLON:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_COLON;
                    run_last_next  = 1'b0;
                    st_next        = after_sep;
                end
            end
            B_COMMA:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_COMMA;
                    run_last_next  = 1'b0;
                    st_next        = after_sep;
                end
            end
            B_SIGN:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_MINUS;
                    run_last_next  = 1'b0;
                    st_next        = B_DIGIT;
                end
            end
            B_DIGIT:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_ZERO + {4'd0, digit};
                    run_last_next  = 1'b0;
                    if (didx_reg == 4'd0)
                    begin
                        if (item_reg.last)
                            st_next = B_NL;
                        else
                        begin
                            run_last_next = 1'b1;
                            st_next       = B_IDLE;
                        end
                    end
                    else
                        didx_next = didx_reg - 4'd1;
                end
            end
            B_NL:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_NL;
                    run_last_next  = 1'b1;
                    st_next        = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule
`default_nettype wire

[hdl/int_csv_telemetry_line_encoder.sv]
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_ready   | channel_value[31:0] signed, frame_end
// out      | output    | out_valid / out_ready | out_byte[7:0], run_last
// cfg      | input     | cfg_we                | cfg_index, cfg_wdata[63:0]
//
// Front end per sample: accept, 32 shift-add-3 BCD steps, queue push once the queue has room.
// Back end pops a sample from the 2-entry queue, then sends 1 to 21 bytes, one per cycle while out_ready holds.
// The front end can take a new sample while the back end still sends the last one.
// Reset clears frame state, queue and output valid; prefix registers reset to zero.
// A stalled output holds in the output register while the front end converts on.
`default_nettype none
module int_csv_telemetry_line_encoder #(
    parameter int PREFIX_MAX = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] channel_value,
    input  wire logic               frame_end,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    run_last,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [63:0]        cfg_wdata
);
    import csvtl_pkg::*;

    logic [63:0]   prefix_chars_reg, prefix_chars_next;
    logic [3:0]    prefix_length_reg, prefix_length_next;
    csvtl_q_stat_t q_stat;
    csvtl_item_t   push_item;
    csvtl_item_t   pop_item;
    logic          push;
    logic          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_chars_reg  <= '0;
            prefix_length_reg <= '0;
        end
        else
        begin
            prefix_chars_reg  <= prefix_chars_next;
            prefix_length_reg <= prefix_length_next;
        end
    end

    always_comb
    begin
        prefix_chars_next  = prefix_chars_reg;
        prefix_length_next = prefix_length_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PREFIX_CHARS:  prefix_chars_next  = cfg_wdata;
                CFG_PREFIX_LENGTH: prefix_length_next = cfg_wdata[3:0];
                default:           prefix_chars_next  = prefix_chars_reg;
            endcase
        end
    end

    csvtl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel_value (channel_value),
        .frame_end     (frame_end),
        .q_stat        (q_stat),
        .push          (push),
        .push_item     (push_item)
    );

    csvtl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    csvtl_back #(
        .PREFIX_MAX (PREFIX_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_item      (pop_item),
        .pop           (pop),
        .prefix_chars  (prefix_chars_reg),
        .prefix_length (prefix_length_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .run_last      (run_last)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("pop from empty queue");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("front end took a request while converting");

    a_last_byte_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_last |->
            (out_byte == CH_NL) || ((out_byte >= CH_ZERO) && (out_byte <= 8'h39)))
        else $error("request closed on a byte that is not a digit or newline");

endmodule
`default_nettype wire

[verif/csvtl_line_checker.sv]
`timescale 1ns / 1ps
module csvtl_line_checker #(
    parameter int PREFIX_MAX = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [31:0] channel_value,
    input  wire logic               frame_end,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [7:0]         out_byte,
    input  wire logic               run_last,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [63:0]        cfg_wdata,
    output int                      mismatches,
    output int                      outstanding
);
    import csvtl_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } line_char_t;

    line_char_t  expected_chars[$];
    logic        frame_started;
    logic [63:0] prefix_word;
    logic [3:0]  prefix_len;

    function automatic void predict_sample(input logic [31:0] raw, input logic last_ch);
        logic [7:0]  text[$];
        logic [7:0]  digs[10];
        logic [31:0] mag;
        int          nd;
        int          n_pre;
        if (!frame_started)
        begin
            n_pre = (prefix_len > PREFIX_MAX) ? PREFIX_MAX : int'(prefix_len);
            if (n_pre > 0)
            begin
                for (int i = 0; i < n_pre; i++)
                begin
                    text.push_back(prefix_word[8*i +: 8]);
                end
                text.push_back(CH_COLON);
            end
        end
        else
        begin
            text.push_back(CH_COMMA);
        end
        mag = raw;
        if (raw[31])
        begin
            text.push_back(CH_MINUS);
            mag = 32'd0 - raw;
        end
        nd = 0;
        do
        begin
            digs[nd] = CH_ZERO + 8'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 0);
        while (nd > 0)
        begin
            nd--;
            text.push_back(digs[nd]);
        end
        if (last_ch)
        begin
            text.push_back(CH_NL);
        end
        frame_started = !last_ch;
        foreach (text[i])
        begin
            expected_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        line_char_t head;
        if (!rst_n)
        begin
            expected_chars.delete();
            frame_started = 1'b0;
            prefix_word   = '0;
            prefix_len    = '0;
            mismatches    = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PREFIX_CHARS)
                    prefix_word = cfg_wdata;
                else
                    prefix_len = cfg_wdata[3:0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("out_byte: expected nothing, got %h", out_byte);
                    mismatches++;
                end
                else
                begin
                    head = expected_chars.pop_front();
                    if (out_byte !== head.ch)
                    begin
                        $error("out_byte: expected %h, got %h", head.ch, out_byte);
                        mismatches++;
                    end
                    if (run_last !== head.last)
                    begin
                        $error("run_last: expected %b, got %b", head.last, run_last);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_sample(channel_value, frame_end);
            end
            outstanding <= expected_chars.size();
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import csvtl_pkg::*;

    localparam int PREFIX_MAX   = 8;
    localparam int WATCHDOG_MAX = 3000;
    localparam int HOLD_AT      = 800;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] channel_value;
    logic               frame_end;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         out_byte;
    logic               run_last;
    logic               cfg_we;
    logic               cfg_index;
    logic [63:0]        cfg_wdata;
    int                 mismatches;
    int                 outstanding;

    int                 samples_sent;
    int                 frames_sent;
    int                 settings_used;
    int                 idle_cycles = 0;
    logic               sender_quiet;

    int_csv_telemetry_line_encoder #(
        .PREFIX_MAX(PREFIX_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .channel_value(channel_value),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    csvtl_line_checker #(
        .PREFIX_MAX(PREFIX_MAX)
    ) line_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .channel_value(channel_value),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random backpressure, one long hold-off, one stretch always ready
    initial
    begin
        int   taken;
        logic held_done;
        taken     = 0;
        held_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (!held_done && taken >= HOLD_AT)
            begin
                held_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (taken >= 1500 && taken < 2100)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 15);
        end
    end

    task automatic send_sample(input logic [31:0] value, input logic last_ch);
        int gap;
        in_valid      <= 1'b1;
        channel_value <= value;
        frame_end     <= last_ch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
        if (last_ch)
            frames_sent++;
        gap = (!sender_quiet && $urandom_range(99) < 15) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and drain every pending request before touching registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_prefix_reg(input logic idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_prefix(input logic [63:0] chars, input logic [3:0] len);
        write_prefix_reg(CFG_PREFIX_CHARS, chars);
        write_prefix_reg(CFG_PREFIX_LENGTH, {60'd0, len});
        settings_used++;
    endtask

    function automatic logic [31:0] pick_value();
        int unsigned sel;
        int unsigned k;
        int unsigned lim;
        logic [31:0] v;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            case ($urandom_range(7))
                0: v = 32'd0;
                1: v = 32'hFFFF_FFFF;
                2: v = 32'h7FFF_FFFF;
                3: v = 32'h8000_0000;
                4: v = 32'h8000_0001;
                5: v = 32'd999_999_999;
                6: v = 32'd1_000_000_000;
                default: v = 32'd10;
            endcase
        end
        else if (sel <= 2)
            v = 32'($urandom_range(40)) - 32'd20;
        else if (sel <= 5)
        begin
            k   = $urandom_range(1, 9);
            lim = 1;
            repeat (k) lim = lim * 10;
            v = $urandom % lim;
            if ($urandom_range(1))
                v = 32'd0 - v;
        end
        else
            v = $urandom;
        return v;
    endfunction

    initial
    begin
        int          frame_len;
        int          in_frame;
        logic        last_ch;
        logic [3:0]  len;
        logic [63:0] chars;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        channel_value <= '0;
        frame_end     <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_PREFIX_CHARS;
        cfg_wdata     <= '0;
        sender_quiet  = 1'b0;
        samples_sent  = 0;
        frames_sent   = 0;
        settings_used = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset prefix: none
        send_sample(32'd0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        wait_drained();
        set_prefix(64'h4847_4645_4443_4241, 4'd8);
        send_sample(32'd1_234_567_890, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'd9, 1'b0);
        send_sample(32'd10, 1'b0);
        send_sample(32'hFFFF_FFF6, 1'b0);
        send_sample(32'd99_999, 1'b1);
        wait_drained();
        // overlong length, zero bytes inside the prefix
        set_prefix(64'h00FF_0041_0000_7F80, 4'd15);
        send_sample(32'd5, 1'b1);
        wait_drained();
        set_prefix(64'h00FF_0041_0000_7F80, 4'd9);
        send_sample(32'hFFFF_FFF9, 1'b0);
        wait_drained();
        // change registers while a frame is open
        set_prefix(64'h0000_0000_005A_5958, 4'd3);
        send_sample(32'd42, 1'b1);
        send_sample(32'd1, 1'b1);
        wait_drained();
        set_prefix(64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
        send_sample(32'd0, 1'b1);
        wait_drained();
        set_prefix(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_sample(32'd7, 1'b0);
        send_sample(32'd100, 1'b1);
        wait_drained();
        set_prefix(64'h3332_3130_2D2C_3A0A, 4'd0);
        send_sample(32'd100, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            chars = {$urandom, $urandom};
            len   = 4'($urandom_range(15));
            if (p == 0)
                len = 4'd0;
            else if (p == 1)
                len = 4'd8;
            else if (p == 2)
                len = 4'd15;
            if (p == 3)
                chars = '0;
            else if (p == 4)
                chars = '1;
            set_prefix(chars, len);
            in_frame  = 0;
            frame_len = $urandom_range(1, 6);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                sender_quiet = (p == 3);
                in_frame++;
                last_ch = (in_frame >= frame_len);
                if ($urandom_range(99) < 10)
                    last_ch = $urandom_range(1);
                if (last_ch)
                begin
                    in_frame  = 0;
                    frame_len = $urandom_range(1, 6);
                end
                send_sample(pick_value(), last_ch);
            end
            sender_quiet = 1'b0;
            wait_drained();
        end

        $display("Sent %0d samples in %0d frames over %0d prefix settings,",
                 samples_sent, frames_sent, settings_used);
        $display("with random stalls on both sides and one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[int_csv_telemetry_line_encoder.f]
hdl/csvtl_pkg.sv
hdl/csvtl_front.sv
hdl/csvtl_queue.sv
hdl/csvtl_back.sv
hdl/int_csv_telemetry_line_encoder.sv
verif/csvtl_line_checker.sv
verif/testbench.sv
